[src/zone_owner_recency_stack_macros.svh]
// Assertion macros for the zone owner recency stack.
// Included by the top level; no other dependencies.
`ifndef ZONE_OWNER_RECENCY_STACK_MACROS_SVH
`define ZONE_OWNER_RECENCY_STACK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ZORS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zone owner recency stack: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ZORS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zone owner recency stack: check failed");

`endif

[src/zors_pkg.sv]
// Shared types and constants for the zone owner recency stack.
// Used by zors_ctrl, zors_dp and zone_owner_recency_stack.
`timescale 1ns / 1ps

package zors_pkg;

    localparam int ZONES_DEF = 8;
    localparam int ZONE_W    = 4;
    localparam int OP_W      = 2;
    localparam int EV_W      = 2;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_END   = 2'd1;
    localparam logic [OP_W-1:0] OP_JOIN  = 2'd2;

    localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EV_W-1:0] EV_CHANGE = 2'd1;
    localparam logic [EV_W-1:0] EV_CLEAR  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ZONE_W-1:0] zone_id;
    } t_in_item;

    typedef struct packed {
        logic              accepted;
        logic [ZONE_W-1:0] owner;
        logic [ZONE_W-1:0] previous_owner;
        logic [EV_W-1:0]   owner_event;
        logic              cleared;
        logic              named_active;
        logic [ZONE_W-1:0] stack_depth;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MODIFY,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load_in;
        logic search;
        logic modify;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_blocked;
    } t_dp_status;

endpackage

[src/zors_ctrl.sv]
// Controller state machine for the zone owner recency stack.
// Depends on zors_pkg; drives commands into zors_dp.
`timescale 1ns / 1ps

module zors_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  zors_pkg::t_dp_status i_status,
    output zors_pkg::t_dp_cmd   o_cmd
);
    import zors_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SEARCH;
            end
            ST_SEARCH: n_state = ST_MODIFY;
            ST_MODIFY: n_state = ST_FINISH;
            ST_FINISH: begin
                if (!i_status.out_blocked) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
            end
            ST_SEARCH: o_cmd.search = 1'b1;
            ST_MODIFY: o_cmd.modify = 1'b1;
            ST_FINISH: o_cmd.load_out = !i_status.out_blocked;
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

[src/zors_dp.sv]
// Datapath for the zone owner recency stack: stack, owner, flags, result register.
// Depends on zors_pkg; commanded by zors_ctrl.
`timescale 1ns / 1ps

module zors_dp #(
    parameter int ZONES = zors_pkg::ZONES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  zors_pkg::t_dp_cmd     i_cmd,
    output zors_pkg::t_dp_status  o_status,
    input  zors_pkg::t_in_item    i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output zors_pkg::t_out_item   o_out
);
    import zors_pkg::*;

    localparam int CW = $clog2(ZONES + 1);

    logic [OP_W-1:0]   r_op;
    logic [ZONE_W-1:0] r_zone;
    logic              r_acc;
    logic [ZONE_W-1:0] r_prev;
    logic [ZONE_W-1:0] r_owner;
    logic [ZONE_W-1:0] n_owner;
    logic [ZONE_W-1:0] r_stack [ZONES];
    logic [ZONE_W-1:0] n_stack [ZONES];
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [ZONES-1:0]  r_flags;
    logic [ZONES-1:0]  n_flags;
    logic [ZONES-1:0]  w_hit;
    logic [ZONES-1:0]  w_pre;
    logic [ZONES-1:0]  r_pre;
    logic              r_found;
    logic [ZONES-1:0]  w_zsel;
    logic              w_full;
    logic              w_in_ok;
    logic [EV_W-1:0]   w_event;
    t_out_item         r_out;
    logic              r_out_valid;

    assign w_in_ok = (i_in.zone_id != '0) && (i_in.zone_id <= ZONE_W'(ZONES))
                     && (i_in.operation <= OP_JOIN);
    assign w_full  = (r_count == CW'(ZONES));

    always_comb begin
        for (int i = 0; i < ZONES; i++) begin
            w_hit[i]  = (r_stack[i] == r_zone) && (CW'(i) < r_count);
            w_zsel[i] = (r_zone == ZONE_W'(i + 1));
        end
        w_pre[0] = w_hit[0];
        for (int i = 1; i < ZONES; i++) begin
            w_pre[i] = w_pre[i-1] | w_hit[i];
        end
    end

    always_comb begin
        n_stack = r_stack;
        n_count = r_count;
        n_flags = r_flags;
        if (i_cmd.modify && r_acc) begin
            case (r_op)
                OP_START: begin
                    if (r_found || !w_full) begin
                        n_stack[0] = r_zone;
                        for (int i = 1; i < ZONES; i++) begin
                            n_stack[i] = r_pre[i-1] ? r_stack[i] : r_stack[i-1];
                        end
                        if (!r_found) n_count = r_count + 1'b1;
                    end
                    n_flags = r_flags | w_zsel;
                end
                OP_END: begin
                    if (r_found) begin
                        for (int i = 0; i < ZONES - 1; i++) begin
                            n_stack[i] = r_pre[i] ? r_stack[i+1] : r_stack[i];
                        end
                        n_stack[ZONES-1] = '0;
                        n_count = r_count - 1'b1;
                        n_flags = r_flags & ~w_zsel;
                    end
                end
                OP_JOIN: begin
                    if (!r_found && !w_full) begin
                        for (int i = 0; i < ZONES; i++) begin
                            if (r_count == CW'(i)) n_stack[i] = r_zone;
                        end
                        n_count = r_count + 1'b1;
                    end
                    n_flags = r_flags | w_zsel;
                end
                default: n_count = r_count;
            endcase
        end
    end

    always_comb begin
        n_owner = r_owner;
        w_event = EV_NONE;
        if (r_acc) begin
            case (r_op)
                OP_START: begin
                    n_owner = r_stack[0];
                    w_event = EV_CHANGE;
                end
                OP_END: begin
                    if (r_found) begin
                        n_owner = r_stack[0];
                        w_event = (r_stack[0] == '0) ? EV_CLEAR : EV_CHANGE;
                    end
                end
                OP_JOIN: begin
                    if (r_owner == '0) n_owner = r_stack[0];
                    if ((n_owner != r_prev) && (n_owner != '0)) w_event = EV_CHANGE;
                end
                default: w_event = EV_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ZONES; i++) begin
                r_stack[i] <= '0;
            end
            r_count     <= '0;
            r_owner     <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_stack <= n_stack;
            r_count <= n_count;
            r_flags <= n_flags;
            if (i_cmd.load_out) begin
                r_owner     <= n_owner;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_in.operation;
            r_zone <= i_in.zone_id;
            r_acc  <= w_in_ok;
            r_prev <= r_owner;
        end
        if (i_cmd.search) begin
            r_pre   <= w_pre;
            r_found <= |w_hit;
        end
        if (i_cmd.load_out) begin
            r_out.accepted       <= r_acc;
            r_out.owner          <= n_owner;
            r_out.previous_owner <= r_prev;
            r_out.owner_event    <= w_event;
            r_out.cleared        <= (n_owner == '0);
            r_out.named_active   <= r_acc & (|(r_flags & w_zsel));
            r_out.stack_depth    <= ZONE_W'(r_count);
        end
    end

    assign o_status.out_blocked = r_out_valid && i_out_stall;
    assign o_out_valid          = r_out_valid;
    assign o_out                = r_out;

endmodule

[src/zone_owner_recency_stack.sv]
// Zone owner recency stack: decides which zone owns a shared output.
// Input channel: valid/stall, one event (operation, zone id) per transaction.
// Output channel: valid/stall, one result per event, held in an output register.
// An event goes through accept, search of the stack, stack update, and the
// result load, and the next event is taken only after its result is loaded.
// The steps are set by the controller's walk through search, update and finish
// for each event.
// Start moves the zone to the top unless the stack is full without it, and makes
// the top owner; end removes it and promotes the new top; join appends it at the
// bottom and takes ownership only when there is none. Zone ids outside 1..ZONES
// and operation 3 are ignored. Synchronous active-low reset empties the stack,
// clears the owner and all active flags, and drops any pending result.
// While the receiver stalls, the result holds; the next event may still be
// processed, and it waits in its final step until the output register frees.
// Depends on zors_pkg, zors_ctrl, zors_dp and the assertion macro header.
`timescale 1ns / 1ps
`include "zone_owner_recency_stack_macros.svh"

module zone_owner_recency_stack #(
    parameter int ZONES = zors_pkg::ZONES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  zors_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output zors_pkg::t_out_item o_out
);
    import zors_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    zors_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    zors_dp #(
        .ZONES (ZONES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    `ZORS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, o_in_stall)
    `ZORS_ASSERT_NEXT(a_result_after_load, i_clk, i_rst_n,
        w_cmd.load_out, o_out_valid && (o_out.stack_depth <= ZONES))
    `ZORS_ASSERT_NOW(a_clear_notice, i_clk, i_rst_n,
        o_out_valid && (o_out.owner_event == EV_CLEAR), o_out.cleared && (o_out.owner == '0))

endmodule

[verif/tb_zone_owner_recency_stack.sv]
// Self-checking testbench for zone_owner_recency_stack: start, end and join events
// against a cycle-free ownership predictor, with random sender gaps and receiver stalls.
// Depends on zors_pkg and the zone_owner_recency_stack RTL.
`timescale 1ns / 1ps

module tb_zone_owner_recency_stack;

    import zors_pkg::*;

    localparam int              ZONES        = ZONES_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;
    localparam int              RESET_CYCLES = 12;
    localparam int              DRAIN_CYCLES = 12;
    localparam int              PRINT_LIMIT  = 20;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;

    // ownership predictor state
    logic [ZONE_W-1:0] zone_order [ZONES];
    int                zone_count;
    logic [ZONE_W-1:0] owner_now;
    bit                zone_live  [ZONES];

    t_out_item expected_results [$];
    t_out_item want_result;
    int        mismatch_count = 0;
    int        result_count   = 0;
    int        burst_left     = 0;
    int        stall_left     = 0;
    int        free_left      = 0;
    bit        calm           = 1'b0;

    zone_owner_recency_stack #(
        .ZONES(ZONES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit zone_listed(logic [ZONE_W-1:0] z);
        for (int i = 0; i < zone_count; i++) begin
            if (zone_order[i] == z) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void zone_remove(logic [ZONE_W-1:0] z);
        int kept;
        kept = 0;
        for (int i = 0; i < zone_count; i++) begin
            if (zone_order[i] != z) begin
                zone_order[kept] = zone_order[i];
                kept++;
            end
        end
        for (int i = kept; i < ZONES; i++) zone_order[i] = '0;
        zone_count = kept;
    endfunction

    function automatic t_out_item predict_owner_event(t_in_item ev);
        t_out_item         res;
        logic [ZONE_W-1:0] z;
        z   = ev.zone_id;
        res = '0;
        res.previous_owner = owner_now;
        if (z == 0 || z > ZONES || ev.operation == OP_UNUSED) begin
            res.accepted = 1'b0;
        end else begin
            res.accepted = 1'b1;
            case (ev.operation)
                OP_START: begin
                    zone_remove(z);
                    if (zone_count < ZONES) begin
                        for (int i = zone_count; i > 0; i--) zone_order[i] = zone_order[i-1];
                        zone_order[0] = z;
                        zone_count++;
                    end
                    zone_live[z-1] = 1'b1;
                    owner_now = (zone_count > 0) ? zone_order[0] : '0;
                    res.owner_event = EV_CHANGE;
                end
                OP_END: begin
                    if (zone_listed(z)) begin
                        zone_live[z-1] = 1'b0;
                        zone_remove(z);
                        owner_now = (zone_count > 0) ? zone_order[0] : '0;
                        res.owner_event = (owner_now == 0) ? EV_CLEAR : EV_CHANGE;
                    end
                end
                OP_JOIN: begin
                    if (!zone_listed(z) && zone_count < ZONES) begin
                        zone_order[zone_count] = z;
                        zone_count++;
                    end
                    zone_live[z-1] = 1'b1;
                    if (owner_now == 0 && zone_count > 0) owner_now = zone_order[0];
                    if (owner_now != res.previous_owner && owner_now != 0) begin
                        res.owner_event = EV_CHANGE;
                    end
                end
                default: begin
                end
            endcase
            res.named_active = zone_live[z-1];
        end
        res.owner       = owner_now;
        res.cleared     = (owner_now == 0);
        res.stack_depth = ZONE_W'(zone_count);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     result_count, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic send_event(logic [OP_W-1:0] op, logic [ZONE_W-1:0] zone);
        t_in_item item;
        int       gap;
        item.operation = op;
        item.zone_id   = zone;
        i_in       <= item;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(predict_owner_event(item));
        if (!calm) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, 9);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // receiver stall runs: mostly short, sometimes long
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (free_left > 0) begin
            i_out_stall <= 1'b0;
            free_left--;
        end else begin
            stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 20)
                                                     : $urandom_range(1, 3);
            free_left  = $urandom_range(0, 8);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with none expected, owner", int'(o_out.owner), 0);
            end else begin
                want_result = expected_results.pop_front();
                if (o_out.accepted !== want_result.accepted)
                    report_mismatch("accepted", int'(o_out.accepted),
                                    int'(want_result.accepted));
                if (o_out.owner !== want_result.owner)
                    report_mismatch("owner", int'(o_out.owner), int'(want_result.owner));
                if (o_out.previous_owner !== want_result.previous_owner)
                    report_mismatch("previous_owner", int'(o_out.previous_owner),
                                    int'(want_result.previous_owner));
                if (o_out.owner_event !== want_result.owner_event)
                    report_mismatch("owner_event", int'(o_out.owner_event),
                                    int'(want_result.owner_event));
                if (o_out.cleared !== want_result.cleared)
                    report_mismatch("cleared", int'(o_out.cleared),
                                    int'(want_result.cleared));
                if (o_out.named_active !== want_result.named_active)
                    report_mismatch("named_active", int'(o_out.named_active),
                                    int'(want_result.named_active));
                if (o_out.stack_depth !== want_result.stack_depth)
                    report_mismatch("stack_depth", int'(o_out.stack_depth),
                                    int'(want_result.stack_depth));
            end
            result_count++;
        end
    end

    task automatic test_ignored_events();
        send_event(OP_START, 4'd0);
        send_event(OP_JOIN, 4'hF);
        send_event(OP_END, ZONE_W'(ZONES + 1));
        send_event(OP_UNUSED, 4'hF);
    endtask

    task automatic test_start_moves_to_top();
        send_event(OP_START, 4'd3);
        send_event(OP_START, 4'd5);
        send_event(OP_START, 4'd3);
        send_event(OP_START, 4'd3);
    endtask

    task automatic test_end_promotes();
        send_event(OP_END, 4'd7);
        send_event(OP_END, 4'd5);
        send_event(OP_END, 4'd3);
    endtask

    task automatic test_join_appends();
        send_event(OP_JOIN, 4'd2);
        send_event(OP_JOIN, 4'd6);
        send_event(OP_JOIN, 4'd2);
        send_event(OP_START, 4'd6);
    endtask

    task automatic test_full_stack();
        send_event(OP_JOIN, 4'd1);
        send_event(OP_JOIN, 4'd3);
        send_event(OP_JOIN, 4'd4);
        send_event(OP_JOIN, 4'd5);
        send_event(OP_JOIN, 4'd7);
        send_event(OP_JOIN, ZONE_W'(ZONES));
        send_event(OP_START, ZONE_W'(ZONES));
        send_event(OP_END, ZONE_W'(ZONES));
    endtask

    task automatic test_random_traffic(int n_events, bit quiet_phase);
        logic [OP_W-1:0]   op;
        logic [ZONE_W-1:0] zone;
        int                pick;
        bit                draining;
        calm     = quiet_phase;
        draining = 1'b0;
        for (int k = 0; k < n_events; k++) begin
            if (zone_count == ZONES) draining = 1'b1;
            else if (zone_count == 0) draining = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                case ($urandom_range(0, 2))
                    0: begin
                        op   = OP_W'($urandom_range(0, 3));
                        zone = '0;
                    end
                    1: begin
                        op   = OP_W'($urandom_range(0, 3));
                        zone = ZONE_W'($urandom_range(ZONES + 1, 15));
                    end
                    default: begin
                        op   = OP_UNUSED;
                        zone = ZONE_W'($urandom_range(0, 15));
                    end
                endcase
            end else begin
                zone = ZONE_W'($urandom_range(1, ZONES));
                pick = $urandom_range(0, 99);
                if (pick < (draining ? 60 : 20)) begin
                    op = OP_END;
                    if (zone_count > 0 && $urandom_range(0, 3) != 0) begin
                        zone = zone_order[$urandom_range(0, zone_count - 1)];
                    end
                end else if (pick < (draining ? 80 : 60)) begin
                    op = OP_START;
                end else begin
                    op = OP_JOIN;
                end
            end
            send_event(op, zone);
        end
    endtask

    initial begin
        zone_count = 0;
        owner_now  = '0;
        for (int i = 0; i < ZONES; i++) begin
            zone_order[i] = '0;
            zone_live[i]  = 1'b0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ignored_events();
        test_start_moves_to_top();
        test_end_promotes();
        test_join_appends();
        test_full_stack();
        test_random_traffic(600, 1'b0);
        test_random_traffic(400, 1'b1);
        test_random_traffic(600, 1'b0);
        test_random_traffic(600, 1'b0);
        i_in_valid <= 1'b0;
        calm = 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
